[src/three_axis_pid_velocity_macros.svh]
// Assertion macros shared by the PID velocity block
`ifndef THREE_AXIS_PID_VELOCITY_MACROS_SVH
`define THREE_AXIS_PID_VELOCITY_MACROS_SVH

// Condition in this cycle implies consequence in the same cycle
`define TAPV_ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Condition in this cycle implies consequence in the next cycle
`define TAPV_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/tapv_pkg.sv]
// Package: constants and types of the three-axis PID velocity block
`default_nettype none
package tapv_pkg;

   localparam int AXES_DEFAULT = 3;
   localparam int FIELD_W      = 31;
   localparam int ERR_W        = 32;
   localparam int OUT_W        = 32;
   localparam int GAIN_W       = 32;
   localparam int LIMIT_W      = 31;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CLAMPED_AXES = 2;
   localparam int FRAC_SHIFT   = 24;

   // results held in the output queue, counted from acceptance to delivery
   localparam int QDEPTH = 4;
   localparam int QPW    = 2;
   localparam int PENDW  = 3;

   // operand, product, sum and shifted-drive widths
   localparam int OPND_W  = 33;
   localparam int PROD_W  = 66;
   localparam int SUM_W   = 68;
   localparam int DRIVE_W = SUM_W - FRAC_SHIFT;

   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_SHIFT - 1);

   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_P       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_I       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_D       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEGRAL_LIM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_LIM   = 3'd4;

   localparam logic [GAIN_W-1:0]  GAIN_P_RESET       = 32'd14763950;
   localparam logic [GAIN_W-1:0]  GAIN_I_RESET       = 32'd3355;
   localparam logic [GAIN_W-1:0]  GAIN_D_RESET       = 32'd28185723;
   localparam logic [LIMIT_W-1:0] INTEGRAL_LIM_RESET = 31'd32768000;
   localparam logic [LIMIT_W-1:0] OUTPUT_LIM_RESET   = 31'd196608;

   // one entry of the per-axis state memory
   typedef struct packed {
      logic signed [ERR_W-1:0] err_prev;
      logic signed [ERR_W-1:0] err_two;
      logic signed [ERR_W-1:0] integ;
   } state_type;

endpackage
`default_nettype wire

[src/three_axis_pid_velocity.sv]
// Three-axis PID velocity block: per-axis state memory, shared multiply pipeline
// Flow: a request is held while its axes issue; each axis passes the update, multiply, sum and limit stages.
// A new request is taken as the last axis of the held one issues, while results pending stay under QDEPTH;
// axes pass one per cycle through the state memory and the shared multiply/accumulate pipeline.
// Reset: synchronous; gains and limits return to defaults, axis state reads as zero
// (per-entry valid bits cleared), queue and pipeline empty.
`default_nettype none
`include "three_axis_pid_velocity_macros.svh"
module three_axis_pid_velocity #(
   parameter int AXES = tapv_pkg::AXES_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   // fields from bit 0: target_x.., position_x.., 31 bits each, zero filled
   input  wire logic [((2*AXES*tapv_pkg::FIELD_W+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // fields from bit 0: velocity_x, velocity_y, velocity_z.., 32 bits each
   output logic [AXES*tapv_pkg::OUT_W-1:0] rsp_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic csr_we,
   input  wire logic [tapv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tapv_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FW    = tapv_pkg::FIELD_W;
   localparam int EW    = tapv_pkg::ERR_W;
   localparam int OW    = tapv_pkg::OUT_W;
   localparam int IN_W  = 2 * AXES * FW;
   localparam int RSP_W = AXES * OW;
   localparam int AXW   = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int QD    = tapv_pkg::QDEPTH;
   localparam int QPW   = tapv_pkg::QPW;
   localparam int PENDW = tapv_pkg::PENDW;
   localparam int OPW   = tapv_pkg::OPND_W;
   localparam int PW    = tapv_pkg::PROD_W;
   localparam int SW    = tapv_pkg::SUM_W;
   localparam int DW    = tapv_pkg::DRIVE_W;

   // configuration registers
   logic [tapv_pkg::GAIN_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [tapv_pkg::LIMIT_W-1:0] integral_lim_ff, output_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff       <= tapv_pkg::GAIN_P_RESET;
         gain_i_ff       <= tapv_pkg::GAIN_I_RESET;
         gain_d_ff       <= tapv_pkg::GAIN_D_RESET;
         integral_lim_ff <= tapv_pkg::INTEGRAL_LIM_RESET;
         output_lim_ff   <= tapv_pkg::OUTPUT_LIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tapv_pkg::REG_GAIN_P:       gain_p_ff <= csr_wdata;
            tapv_pkg::REG_GAIN_I:       gain_i_ff <= csr_wdata;
            tapv_pkg::REG_GAIN_D:       gain_d_ff <= csr_wdata;
            tapv_pkg::REG_INTEGRAL_LIM: integral_lim_ff <= csr_wdata[tapv_pkg::LIMIT_W-1:0];
            tapv_pkg::REG_OUTPUT_LIM:   output_lim_ff <= csr_wdata[tapv_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- intake
   logic            hold_valid_ff;
   logic [IN_W-1:0] hold_data_ff;
   logic [AXW-1:0]  axis_ff;
   logic [PENDW-1:0] pending_ff;
   logic            issue, issue_last, req_xfer, rsp_xfer;

   assign issue      = hold_valid_ff;
   assign issue_last = hold_valid_ff && (axis_ff == AXW'(AXES - 1));
   assign req_tready = (pending_ff < PENDW'(QD)) && (!hold_valid_ff || issue_last);
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         axis_ff       <= '0;
         pending_ff    <= '0;
      end else begin
         if (req_xfer) begin
            hold_valid_ff <= 1'b1;
         end else if (issue_last) begin
            hold_valid_ff <= 1'b0;
         end
         if (issue_last) begin
            axis_ff <= '0;
         end else if (issue) begin
            axis_ff <= axis_ff + AXW'(1);
         end
         pending_ff <= pending_ff + PENDW'(req_xfer) - PENDW'(rsp_xfer);
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         hold_data_ff <= req_tdata[IN_W-1:0];
      end
   end

   // error of the axis being issued
   logic signed [FW-1:0] tgt, pos;
   logic signed [EW-1:0] err_in;
   assign tgt    = hold_data_ff[int'(axis_ff) * FW +: FW];
   assign pos    = hold_data_ff[(AXES + int'(axis_ff)) * FW +: FW];
   assign err_in = {tgt[FW-1], tgt} - {pos[FW-1], pos};

   // ---------------------------------------------------------- state memory
   tapv_pkg::state_type state_mem [AXES];
   logic [AXES-1:0]     state_valid_ff;
   tapv_pkg::state_type mem_rd_ff;
   logic                rd_valid_ff;

   // stage 1 control and payload
   logic                s1_valid_ff, s1_last_ff;
   logic [AXW-1:0]      s1_axis_ff;
   logic signed [EW-1:0] s1_err_ff;
   logic                fwd_ff;
   tapv_pkg::state_type fwd_data_ff;
   tapv_pkg::state_type wb_data;

   always_ff @(posedge clock) begin
      mem_rd_ff <= state_mem[axis_ff];
      if (s1_valid_ff) begin
         state_mem[s1_axis_ff] <= wb_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         rd_valid_ff <= state_valid_ff[axis_ff];
         if (s1_valid_ff) begin
            state_valid_ff[s1_axis_ff] <= 1'b1;
         end
      end
   end

   // ----------------------------------------------------- stage 1: update
   tapv_pkg::state_type  st;
   logic signed [EW:0]   integ_sum, ilim, deriv_in;
   logic signed [EW-1:0] integ_in;

   always_comb begin
      if (fwd_ff) begin
         st = fwd_data_ff;
      end else if (rd_valid_ff) begin
         st = mem_rd_ff;
      end else begin
         st = '0;
      end
      integ_sum = {st.integ[EW-1], st.integ} + {s1_err_ff[EW-1], s1_err_ff};
      ilim      = {2'b00, integral_lim_ff};
      if (integ_sum > ilim) begin
         integ_in = ilim[EW-1:0];
      end else if (integ_sum < -ilim) begin
         integ_in = EW'(-ilim);
      end else begin
         integ_in = integ_sum[EW-1:0];
      end
      deriv_in = {s1_err_ff[EW-1], s1_err_ff} - {st.err_two[EW-1], st.err_two};
      wb_data.err_prev = s1_err_ff;
      wb_data.err_two  = st.err_prev;
      wb_data.integ    = integ_in;
   end

   // stage 2 registers
   logic                s2_valid_ff, s2_last_ff;
   logic [AXW-1:0]      s2_axis_ff;
   logic signed [EW-1:0] s2_err_ff, s2_integ_ff;
   logic signed [EW:0]  s2_deriv_ff;

   // ---------------------------------------------------- stage 2: multiply
   logic signed [OPW-1:0] op_p, op_i, op_d, g_p, g_i, g_d;
   assign op_p = {s2_err_ff[EW-1], s2_err_ff};
   assign op_i = {s2_integ_ff[EW-1], s2_integ_ff};
   assign op_d = s2_deriv_ff;
   assign g_p  = {1'b0, gain_p_ff};
   assign g_i  = {1'b0, gain_i_ff};
   assign g_d  = {1'b0, gain_d_ff};

   logic                s3_valid_ff, s3_last_ff;
   logic [AXW-1:0]      s3_axis_ff;
   logic signed [PW-1:0] s3_pp_ff, s3_pi_ff, s3_pd_ff;

   // ------------------------------------------------ stage 3: sum and round
   logic signed [SW-1:0] sum_in;
   assign sum_in = SW'(s3_pp_ff) + SW'(s3_pi_ff) + SW'(s3_pd_ff) + tapv_pkg::ROUND_HALF;

   logic                s4_valid_ff, s4_last_ff;
   logic [AXW-1:0]      s4_axis_ff;
   logic signed [DW-1:0] s4_drive_ff;

   // ------------------------------------------- stage 4: saturate and limit
   logic signed [OW-1:0] sat, vel;
   logic signed [OW-1:0] olim;
   logic                 clamp_en;
   logic [RSP_W-1:0]     asm_ff, asm_next;
   logic                 push;

   always_comb begin
      if (s4_drive_ff > DW'(signed'({1'b0, {(OW-1){1'b1}}}))) begin
         sat = {1'b0, {(OW-1){1'b1}}};
      end else if (s4_drive_ff < DW'(signed'({1'b1, {(OW-1){1'b0}}}))) begin
         sat = {1'b1, {(OW-1){1'b0}}};
      end else begin
         sat = s4_drive_ff[OW-1:0];
      end
      olim     = {1'b0, output_lim_ff};
      clamp_en = (int'(s4_axis_ff) < tapv_pkg::CLAMPED_AXES) && (output_lim_ff != '0);
      vel      = sat;
      if (clamp_en) begin
         if (sat > olim) begin
            vel = olim;
         end else if (sat < -olim) begin
            vel = -olim;
         end
      end
      asm_next = asm_ff;
      asm_next[int'(s4_axis_ff) * OW +: OW] = vel;
   end

   assign push = s4_valid_ff && s4_last_ff;

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      s1_axis_ff  <= axis_ff;
      s1_last_ff  <= issue_last;
      s1_err_ff   <= err_in;
      // bypass a write-back to the entry being read in the same cycle
      fwd_ff      <= s1_valid_ff && (s1_axis_ff == axis_ff);
      fwd_data_ff <= wb_data;

      s2_axis_ff  <= s1_axis_ff;
      s2_last_ff  <= s1_last_ff;
      s2_err_ff   <= s1_err_ff;
      s2_integ_ff <= integ_in;
      s2_deriv_ff <= deriv_in;

      s3_axis_ff  <= s2_axis_ff;
      s3_last_ff  <= s2_last_ff;
      s3_pp_ff    <= op_p * g_p;
      s3_pi_ff    <= op_i * g_i;
      s3_pd_ff    <= op_d * g_d;

      s4_axis_ff  <= s3_axis_ff;
      s4_last_ff  <= s3_last_ff;
      s4_drive_ff <= sum_in[SW-1:tapv_pkg::FRAC_SHIFT];

      if (s4_valid_ff) begin
         asm_ff <= asm_next;
      end
   end

   // ------------------------------------------------------- result queue
   logic [RSP_W-1:0] q_mem [QD];
   logic [QPW-1:0]   q_wr_ff, q_rd_ff;
   logic [PENDW-1:0] q_count_ff;

   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_tdata  = q_mem[q_rd_ff];
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[q_wr_ff] <= asm_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff    <= '0;
         q_rd_ff    <= '0;
         q_count_ff <= '0;
      end else begin
         if (push) begin
            q_wr_ff <= q_wr_ff + QPW'(1);
         end
         if (rsp_xfer) begin
            q_rd_ff <= q_rd_ff + QPW'(1);
         end
         q_count_ff <= q_count_ff + PENDW'(push) - PENDW'(rsp_xfer);
      end
   end

   // ------------------------------------------------------------ checks
   `TAPV_ASSERT_IMPLIES(a_pending_bound, clock, reset, 1'b1, pending_ff <= PENDW'(QD))
   `TAPV_ASSERT_IMPLIES(a_queue_within_pending, clock, reset, 1'b1, q_count_ff <= pending_ff)
   `TAPV_ASSERT_IMPLIES(a_push_has_room, clock, reset, push, q_count_ff < PENDW'(QD))
   `TAPV_ASSERT_NEXT(a_hold_frees, clock, reset, issue_last && !req_xfer, !hold_valid_ff)

endmodule
`default_nettype wire
